// File: design/sovq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sovq_pkg;

    localparam int SLOTS_DEFAULT = 1024;
    localparam int NUM_TYPES = 4;
    localparam int NUM_RADII = 4;

    localparam int SLOT_W = 10;
    localparam int KIND_W = 2;
    localparam int COORD_W = 16;
    localparam int RADIUS_W = 16;
    localparam int COUNT_FIELD_W = 11;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 3'd4;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Arithmetic widths of the distance datapath.
    localparam int MAG_W = COORD_W;
    localparam int SQ_W = 2 * MAG_W;
    localparam int D2_W = SQ_W + 2;
    localparam int RSUM_W = RADIUS_W + 1;
    localparam int RSQ_W = 2 * RSUM_W;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } entry_t;

    typedef logic [NUM_RADII-1:0][RADIUS_W-1:0] radii_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } dist_status_t;

    // Number of restoring subtract steps that bring a slot field below the slot count.
    function automatic int mod_steps(input int slots);
        int n;
        n = 0;
        for (int k = 0; k <= SLOT_W; k++) begin
            if ((longint'(slots) << k) < (longint'(1) << SLOT_W)) begin
                n = k + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [RADIUS_W-1:0] radius_of(input radii_t radii,
                                                      input logic [KIND_W-1:0] kind);
        logic [KIND_W-1:0] k;
        k = kind;
        if (int'(kind) >= NUM_TYPES) begin
            k = KIND_W'(NUM_TYPES - 1);
        end
        return radii[k];
    endfunction

endpackage

`default_nettype wire

// File: design/sovq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sovq_req_if;
    import sovq_pkg::*;

    logic valid;
    logic ready;
    logic command;
    logic [SLOT_W-1:0] slot;
    logic [KIND_W-1:0] kind;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;

    modport source (
        output valid, command, slot, kind, pos_x, pos_y, pos_z,
        input ready
    );

    modport sink (
        input valid, command, slot, kind, pos_x, pos_y, pos_z,
        output ready
    );
endinterface

`default_nettype wire

// File: design/sovq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sovq_rsp_if;
    import sovq_pkg::*;

    logic valid;
    logic ready;
    logic overlap;
    logic [SLOT_W-1:0] queried_slot;

    modport source (
        output valid, overlap, queried_slot,
        input ready
    );

    modport sink (
        input valid, overlap, queried_slot,
        output ready
    );
endinterface

`default_nettype wire

// File: design/sovq_store.sv
`timescale 1ns / 1ps
`default_nettype none

module sovq_store #(
    parameter int SLOTS = sovq_pkg::SLOTS_DEFAULT,
    parameter int AW = $clog2(SLOTS)
) (
    input logic clk,
    input logic we,
    input logic [AW-1:0] waddr,
    input sovq_pkg::entry_t wdata,
    input logic re,
    input logic [AW-1:0] raddr,
    output sovq_pkg::entry_t rdata
);
    import sovq_pkg::*;

    entry_t mem [SLOTS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/sovq_dist.sv
`timescale 1ns / 1ps
`default_nettype none

module sovq_dist (
    input logic clk,
    input logic rst_n,
    input logic clear,
    input logic cand_valid,
    input sovq_pkg::entry_t cand,
    input sovq_pkg::entry_t target,
    input sovq_pkg::radii_t radii,
    output sovq_pkg::dist_status_t status
);
    import sovq_pkg::*;

    logic s1_valid_reg;
    logic [MAG_W-1:0] adx_reg, ady_reg, adz_reg;
    logic [RSUM_W-1:0] rsum_reg;

    logic s2_valid_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [RSQ_W-1:0] rsq_reg;

    logic hit_reg;
    logic hit_next;
    logic [D2_W-1:0] d2;

    function automatic logic [MAG_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                  input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0] n;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        n = -d;
        return d[COORD_W] ? n[MAG_W-1:0] : d[MAG_W-1:0];
    endfunction

    // Stage 1: per-axis distance magnitude and radius sum.
    always_ff @(posedge clk)
    begin
        adx_reg <= abs_diff(target.x, cand.x);
        ady_reg <= abs_diff(target.y, cand.y);
        adz_reg <= abs_diff(target.z, cand.z);
        rsum_reg <= RSUM_W'(radius_of(radii, target.kind)) +
                    RSUM_W'(radius_of(radii, cand.kind));
    end

    // Stage 2: squares.
    always_ff @(posedge clk)
    begin
        sqx_reg <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
        sqy_reg <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
        sqz_reg <= SQ_W'(adz_reg) * SQ_W'(adz_reg);
        rsq_reg <= RSQ_W'(rsum_reg) * RSQ_W'(rsum_reg);
    end

    // Stage 3: sum, compare and fold into the running hit flag.
    always_comb
    begin
        d2 = D2_W'(sqx_reg) + D2_W'(sqy_reg) + D2_W'(sqz_reg);
        hit_next = hit_reg;
        if (s2_valid_reg && (d2 <= D2_W'(rsq_reg)))
        begin
            hit_next = 1'b1;
        end
        if (clear)
        begin
            hit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cand_valid;
            s2_valid_reg <= s1_valid_reg;
            hit_reg <= hit_next;
        end
    end

    assign status.busy = s1_valid_reg | s2_valid_reg;
    assign status.hit = hit_reg;

endmodule

`default_nettype wire

// File: design/sphere_overlap_query_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Load: the slot index is first reduced modulo SLOTS in restoring subtract steps (none when
// SLOTS >= 1024), then the word is written. Query: the single memory read port visits one
// slot per cycle over count slots, count = min(slots_in_use, SLOTS). One item is in work at a
// time; a finished result waits in the output register.
// Reset clears control and configuration (radii 256, slots_in_use 0); the slot memory is
// not cleared and holds undefined data until loaded.
module sphere_overlap_query_core #(
    parameter int SLOTS = sovq_pkg::SLOTS_DEFAULT
) (
    input logic clk,
    input logic rst_n,
    sovq_req_if.sink req,
    sovq_rsp_if.source rsp,
    input logic cfg_we,
    input logic [sovq_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [sovq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sovq_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MOD_STEPS = mod_steps(SLOTS);
    localparam int STEP_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
    localparam int DIV_INIT = (MOD_STEPS > 0) ? (SLOTS << (MOD_STEPS - 1)) : 0;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_REDUCE   = 7'b0000010,
        ST_DISPATCH = 7'b0000100,
        ST_TARGET   = 7'b0001000,
        ST_SCAN     = 7'b0010000,
        ST_DRAIN    = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    radii_t radii_reg;
    logic [COUNT_FIELD_W-1:0] slots_in_use_reg;

    logic cmd_reg;
    logic [SLOT_W-1:0] slot_field_reg;
    logic [SLOT_W-1:0] rem_reg, rem_next;
    logic [SLOT_W-1:0] div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;
    entry_t load_reg;
    entry_t target_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic tag_reg, tag_next;

    logic rsp_valid_reg, rsp_valid_next;
    logic overlap_reg;
    logic [SLOT_W-1:0] queried_slot_reg;

    logic mem_we;
    logic mem_re;
    logic [AW-1:0] mem_raddr;
    entry_t mem_rdata;
    logic dist_clear;
    logic issue;
    dist_status_t dist_status;

    logic accept;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radii_reg <= {NUM_RADII{RADIUS_RESET}};
            slots_in_use_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS0: radii_reg[0] <= cfg_data[RADIUS_W-1:0];
                CFG_RADIUS1: radii_reg[1] <= cfg_data[RADIUS_W-1:0];
                CFG_RADIUS2: radii_reg[2] <= cfg_data[RADIUS_W-1:0];
                CFG_RADIUS3: radii_reg[3] <= cfg_data[RADIUS_W-1:0];
                CFG_SLOTS_IN_USE: slots_in_use_reg <= COUNT_FIELD_W'(cfg_data);
                default: ;
            endcase
        end
    end

    // Accepted word payload, and the target entry read for a query.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= req.command;
            slot_field_reg <= req.slot;
            load_reg.kind <= req.kind;
            load_reg.x <= req.pos_x;
            load_reg.y <= req.pos_y;
            load_reg.z <= req.pos_z;
        end
        if (state_reg == ST_TARGET)
        begin
            target_reg <= mem_rdata;
        end
    end

    assign issue = ((state_reg == ST_TARGET) || (state_reg == ST_SCAN)) &&
                   (idx_reg < count_reg);

    always_comb
    begin
        state_next = state_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        step_next = step_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        tag_next = 1'b0;
        rsp_valid_next = rsp_valid_reg;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_raddr = AW'(rem_reg);
        dist_clear = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rem_next = req.slot;
                    div_next = SLOT_W'(DIV_INIT);
                    step_next = STEP_W'(MOD_STEPS > 0 ? MOD_STEPS - 1 : 0);
                    state_next = (MOD_STEPS > 0) ? ST_REDUCE : ST_DISPATCH;
                end
            end
            ST_REDUCE:
            begin
                // Restoring reduction of the slot field modulo the slot count.
                if (rem_reg >= div_reg)
                begin
                    rem_next = rem_reg - div_reg;
                end
                div_next = div_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (cmd_reg == CMD_LOAD)
                begin
                    mem_we = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re = 1'b1;
                    dist_clear = 1'b1;
                    idx_next = '0;
                    if (32'(slots_in_use_reg) > 32'(SLOTS))
                    begin
                        count_next = CW'(SLOTS);
                    end
                    else
                    begin
                        count_next = CW'(slots_in_use_reg);
                    end
                    state_next = ST_TARGET;
                end
            end
            ST_TARGET, ST_SCAN:
            begin
                if (issue)
                begin
                    mem_re = 1'b1;
                    mem_raddr = idx_reg[AW-1:0];
                    tag_next = (32'(idx_reg) != 32'(rem_reg));
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!tag_reg && !dist_status.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rem_reg <= '0;
            div_reg <= '0;
            step_reg <= '0;
            count_reg <= '0;
            idx_reg <= '0;
            tag_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg <= rem_next;
            div_reg <= div_next;
            step_reg <= step_next;
            count_reg <= count_next;
            idx_reg <= idx_next;
            tag_reg <= tag_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && (!rsp_valid_reg || rsp.ready))
        begin
            overlap_reg <= dist_status.hit;
            queried_slot_reg <= slot_field_reg;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.overlap = overlap_reg;
    assign rsp.queried_slot = queried_slot_reg;

    sovq_store #(
        .SLOTS(SLOTS),
        .AW(AW)
    ) u_store (
        .clk(clk),
        .we(mem_we),
        .waddr(AW'(rem_reg)),
        .wdata(load_reg),
        .re(mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    sovq_dist u_dist (
        .clk(clk),
        .rst_n(rst_n),
        .clear(dist_clear),
        .cand_valid(tag_reg),
        .cand(mem_rdata),
        .target(target_reg),
        .radii(radii_reg),
        .status(dist_status)
    );

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sovq_pkg::*;

    // Slow enough for every query to walk a full table while the receiver stalls.
    localparam int RUN_LIMIT_NS = 12_000_000;
    // A load gives no word back after it is taken.
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES = 14;
    localparam int PHASE_WORDS = 40;
    localparam int SMALL_COUNT_MAX = 96;
    // Register index past the end of the list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic command;
        logic [SLOT_W-1:0] slot;
        logic [KIND_W-1:0] kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } req_word_t;

    typedef struct {
        logic overlap;
        logic [SLOT_W-1:0] slot;
    } answer_t;

    typedef enum {ROW_LOAD, ROW_QUERY, ROW_REG} row_op_t;
    typedef enum {ANS_PREDICTED, ANS_CLEAR, ANS_OVERLAP} answer_mode_t;

    // For register rows, index is the register and value its data.
    typedef struct {
        row_op_t op;
        int index;
        int kind;
        int x;
        int y;
        int z;
        int value;
        answer_mode_t answer;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sovq_req_if req_if ();
    sovq_rsp_if rsp_if ();

    sphere_overlap_query_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_if),
        .rsp(rsp_if),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic signed [COORD_W-1:0] slot_x [SLOTS_DEFAULT];
    logic signed [COORD_W-1:0] slot_y [SLOTS_DEFAULT];
    logic signed [COORD_W-1:0] slot_z [SLOTS_DEFAULT];
    logic [KIND_W-1:0] slot_kind [SLOTS_DEFAULT];
    bit slot_loaded [SLOTS_DEFAULT];
    int loaded_list [$];
    int loaded_prefix = 0;

    logic [RADIUS_W-1:0] radius_shadow [NUM_RADII];
    logic [COUNT_FIELD_W-1:0] count_shadow;

    answer_t answers_due [$];
    dir_row_t directed_rows [$];
    int mismatches = 0;

    int send_idle_pct = 9;
    int recv_idle_pct = 64;
    int rsp_hold_cycles = 0;

    int cluster_x;
    int cluster_y;
    int cluster_z;
    int cluster_spread = 256;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    function automatic int compared_slots();
        return (count_shadow > SLOTS_DEFAULT) ? SLOTS_DEFAULT : int'(count_shadow);
    endfunction

    function automatic logic predict_overlap(input int target);
        longint dx;
        longint dy;
        longint dz;
        longint rsum;
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < compared_slots(); i++) begin
            if (i == target)
                continue;
            dx = longint'(slot_x[target]) - longint'(slot_x[i]);
            dy = longint'(slot_y[target]) - longint'(slot_y[i]);
            dz = longint'(slot_z[target]) - longint'(slot_z[i]);
            rsum = longint'(radius_shadow[slot_kind[target]])
                 + longint'(radius_shadow[slot_kind[i]]);
            if (dx * dx + dy * dy + dz * dz <= rsum * rsum)
                hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_RADIUS0, CFG_RADIUS1, CFG_RADIUS2, CFG_RADIUS3:
                radius_shadow[index] = data[RADIUS_W-1:0];
            CFG_SLOTS_IN_USE:
                count_shadow = data[COUNT_FIELD_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Stop offering, let every result come home, then cover a trailing load.
    task automatic settle();
        req_if.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_word(input req_word_t w, input answer_mode_t answer);
        answer_t due;
        int s;
        while (int'($urandom_range(0, 99)) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.command <= w.command;
        req_if.slot <= w.slot;
        req_if.kind <= w.kind;
        req_if.pos_x <= w.x;
        req_if.pos_y <= w.y;
        req_if.pos_z <= w.z;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        s = int'(w.slot);
        if (w.command == CMD_LOAD) begin
            slot_x[s] = w.x;
            slot_y[s] = w.y;
            slot_z[s] = w.z;
            slot_kind[s] = w.kind;
            if (!slot_loaded[s]) begin
                slot_loaded[s] = 1'b1;
                loaded_list.push_back(s);
            end
            while (loaded_prefix < SLOTS_DEFAULT && slot_loaded[loaded_prefix])
                loaded_prefix++;
        end else begin
            due.slot = w.slot;
            if (answer == ANS_PREDICTED)
                due.overlap = predict_overlap(s);
            else
                due.overlap = (answer == ANS_OVERLAP);
            answers_due.push_back(due);
        end
    endtask

    function automatic logic signed [COORD_W-1:0] near(input int center);
        return COORD_W'(center + int'($urandom_range(0, 2 * cluster_spread)) - cluster_spread);
    endfunction

    // Most words land in a tight cluster so that queries hit; a few are scattered
    // anywhere in the coordinate range.
    function automatic req_word_t random_word(input logic command, input int slot);
        req_word_t w;
        w.command = command;
        w.slot = SLOT_W'(slot);
        w.kind = KIND_W'($urandom);
        if ($urandom_range(0, 99) < 15) begin
            w.x = COORD_W'($urandom);
            w.y = COORD_W'($urandom);
            w.z = COORD_W'($urandom);
        end else begin
            w.x = near(cluster_x);
            w.y = near(cluster_y);
            w.z = near(cluster_z);
        end
        return w;
    endfunction

    function automatic logic [RADIUS_W-1:0] pick_radius();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return RADIUS_W'($urandom_range(cluster_spread / 4, cluster_spread));
        endcase
    endfunction

    task automatic configure_phase();
        int count;
        int span;
        cluster_x = int'($urandom_range(0, 32000)) - 16000;
        cluster_y = int'($urandom_range(0, 32000)) - 16000;
        cluster_z = int'($urandom_range(0, 32000)) - 16000;
        cluster_spread = 32 << (2 * $urandom_range(0, 3));
        for (int t = 0; t < NUM_RADII; t++)
            write_reg(CFG_RADIUS0 + CFG_IDX_W'(t), pick_radius());
        span = (loaded_prefix < SMALL_COUNT_MAX) ? loaded_prefix : SMALL_COUNT_MAX;
        count = int'($urandom_range(0, span));
        // Bits above the count field ride along and must be dropped.
        write_reg(CFG_SLOTS_IN_USE,
                  {(CFG_DATA_W - COUNT_FIELD_W)'($urandom), COUNT_FIELD_W'(count)});
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    endtask

    task automatic run_phase(input int words, input bit pause_midway);
        int slot;
        int roll;
        for (int k = 0; k < words; k++) begin
            if (pause_midway && k == words / 2) begin
                req_if.valid <= 1'b0;
                while (answers_due.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            if ($urandom_range(0, 99) < 40) begin
                roll = int'($urandom_range(0, 9));
                if (roll < 5 && loaded_prefix < SLOTS_DEFAULT)
                    slot = loaded_prefix;
                else if (roll < 8 && loaded_prefix > 0)
                    slot = int'($urandom_range(0, loaded_prefix - 1));
                else
                    slot = int'($urandom_range(0, SLOTS_DEFAULT - 1));
                send_word(random_word(CMD_LOAD, slot), ANS_PREDICTED);
            end else begin
                // Every slot below the count is loaded, so either choice is safe.
                if (compared_slots() > 0 && $urandom_range(0, 99) < 70)
                    slot = int'($urandom_range(0, compared_slots() - 1));
                else
                    slot = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                send_word(random_word(CMD_QUERY, slot), ANS_PREDICTED);
            end
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : receiver
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_hold_cycles > 0) begin
                rsp_hold_cycles--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= (int'($urandom_range(0, 99)) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin : check_answers
        answer_t due;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (answers_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word for slot %0d",
                                          rsp_if.queried_slot));
            end else begin
                due = answers_due.pop_front();
                if (rsp_if.overlap !== due.overlap)
                    report_mismatch($sformatf("slot %0d overlap %b, expected %b",
                                              due.slot, rsp_if.overlap, due.overlap));
                if (rsp_if.queried_slot !== due.slot)
                    report_mismatch($sformatf("queried_slot %0d, expected %0d",
                                              rsp_if.queried_slot, due.slot));
            end
        end
    end

    initial begin : stimulus
        dir_row_t row;
        req_word_t w;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.command = CMD_LOAD;
        req_if.slot = '0;
        req_if.kind = '0;
        req_if.pos_x = '0;
        req_if.pos_y = '0;
        req_if.pos_z = '0;
        for (int t = 0; t < NUM_RADII; t++)
            radius_shadow[t] = RADIUS_RESET;
        count_shadow = '0;

        // op, index, kind, x, y, z, value, answer
        directed_rows = '{
            '{ROW_LOAD, 0, 0, 0, 0, 0, 0, ANS_PREDICTED},
            '{ROW_LOAD, 1, 1, 512, 0, 0, 0, ANS_PREDICTED},
            // Nothing is compared while the count is zero.
            '{ROW_QUERY, 0, 0, 0, 0, 0, 0, ANS_CLEAR},
            '{ROW_REG, CFG_SLOTS_IN_USE, 0, 0, 0, 0, 1, ANS_PREDICTED},
            // The only slot in range is the queried one, which is skipped.
            '{ROW_QUERY, 0, 3, -1, -1, -1, 0, ANS_CLEAR},
            '{ROW_REG, CFG_SLOTS_IN_USE, 0, 0, 0, 0, 2, ANS_PREDICTED},
            // Two spheres of radius 256 that are 512 units apart just touch.
            '{ROW_QUERY, 0, 0, 0, 0, 0, 0, ANS_OVERLAP},
            '{ROW_QUERY, 1, 0, 0, 0, 0, 0, ANS_OVERLAP},
            '{ROW_LOAD, 1, 1, 513, 0, 0, 0, ANS_PREDICTED},
            '{ROW_QUERY, 1, 0, 0, 0, 0, 0, ANS_CLEAR},
            '{ROW_LOAD, 2, 3, 32767, -32768, 32767, 0, ANS_PREDICTED},
            '{ROW_LOAD, 1023, 2, -32768, 32767, -32768, 0, ANS_PREDICTED},
            '{ROW_QUERY, 1023, 1, 32767, 32767, 32767, 0, ANS_PREDICTED},
            '{ROW_QUERY, 2, 0, 0, 0, 0, 0, ANS_PREDICTED},
            '{ROW_REG, CFG_RADIUS0, 0, 0, 0, 0, 0, ANS_PREDICTED},
            '{ROW_REG, CFG_RADIUS1, 0, 0, 0, 0, 0, ANS_PREDICTED},
            '{ROW_LOAD, 1, 1, 0, 0, 0, 0, ANS_PREDICTED},
            // Zero radii still overlap when the centers coincide.
            '{ROW_QUERY, 1, 0, 0, 0, 0, 0, ANS_OVERLAP},
            '{ROW_REG, CFG_RADIUS2, 0, 0, 0, 0, 65535, ANS_PREDICTED},
            '{ROW_REG, CFG_RADIUS3, 0, 0, 0, 0, 65535, ANS_PREDICTED},
            '{ROW_REG, CFG_SLOTS_IN_USE, 0, 0, 0, 0, 3, ANS_PREDICTED},
            '{ROW_QUERY, 2, 0, 0, 0, 0, 0, ANS_PREDICTED},
            '{ROW_QUERY, 1023, 0, 0, 0, 0, 0, ANS_PREDICTED},
            '{ROW_REG, CFG_UNUSED, 0, 0, 0, 0, 65535, ANS_PREDICTED},
            '{ROW_QUERY, 0, 0, 0, 0, 0, 0, ANS_PREDICTED},
            '{ROW_REG, CFG_SLOTS_IN_USE, 0, 0, 0, 0, 16'hF802, ANS_PREDICTED},
            '{ROW_QUERY, 1023, 0, 0, 0, 0, 0, ANS_PREDICTED},
            '{ROW_QUERY, 2, 0, 0, 0, 0, 0, ANS_PREDICTED}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            if (row.op == ROW_REG) begin
                settle();
                write_reg(CFG_IDX_W'(row.index), CFG_DATA_W'(row.value));
            end else begin
                w.command = (row.op == ROW_QUERY) ? CMD_QUERY : CMD_LOAD;
                w.slot = SLOT_W'(row.index);
                w.kind = KIND_W'(row.kind);
                w.x = COORD_W'(row.x);
                w.y = COORD_W'(row.y);
                w.z = COORD_W'(row.z);
                send_word(w, row.answer);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == PHASES / 3) begin
                send_idle_pct = 64;
                recv_idle_pct = 9;
            end
            if (phase == 2 * PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            configure_phase();
            // The output word backs up and the block has to refuse new words.
            if (phase == 1 || phase == 8)
                rsp_hold_cycles = 400;
            run_phase(PHASE_WORDS, phase == 3);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
